// ===== rtl/wla_pkg.sv =====
// Shared widths, register indexes, reset defaults and state codes for the level alarm.
`default_nettype none

package wla_pkg;

  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned RAW_W     = 10;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned PERIOD_W  = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;
  localparam int unsigned PROD_W    = LEVEL_W + RAW_W;

  localparam int unsigned WINDOW_DEPTH_DEF   = 8;
  localparam int unsigned RAW_FULL_SCALE_DEF = 1023;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MAX      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISABLE_MARGIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ON_COUNT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_COUNT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD  = 3'd5;

  // reset values
  localparam logic [LEVEL_W-1:0]  LEVEL_MIN_RST      = 16'd0;
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX_RST      = 16'd100;
  localparam logic [LEVEL_W-1:0]  DISABLE_MARGIN_RST = 16'd5;
  localparam logic [COUNT_W-1:0]  ON_COUNT_RST       = 7'd6;
  localparam logic [COUNT_W-1:0]  OFF_COUNT_RST      = 7'd2;
  localparam logic [PERIOD_W-1:0] UPDATE_PERIOD_RST  = 24'd1000;

  localparam logic [PERIOD_W-1:0] ELAPSED_MAX = {PERIOD_W{1'b1}};

  // item kinds
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_MEASURE = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_WALK = 5'b01000,
    ST_FIN  = 5'b10000
  } wla_state_e;

endpackage

`default_nettype wire

// ===== rtl/wla_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wla_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/wla_div.sv =====
// Fixed-divisor divider by reciprocal multiply; registers the dividend, then the quotient.
`default_nettype none

module wla_div #(
  parameter int unsigned DIVIDEND_W = 26,
  parameter int unsigned DIVISOR    = 1023
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  output logic                       done_o,
  output logic      [DIVIDEND_W-1:0] quotient_o
);

  // floor(n / DIVISOR) == (n * RECIP) >> SHIFT for every n below 2**DIVIDEND_W,
  // with RECIP = ceil(2**SHIFT / DIVISOR) and SHIFT = DIVIDEND_W + clog2(DIVISOR)
  localparam int unsigned     SHIFT   = DIVIDEND_W + $clog2(DIVISOR);
  localparam int unsigned     RW      = DIVIDEND_W + 1;
  localparam int unsigned     MW      = DIVIDEND_W + RW;
  localparam longint unsigned RECIP_L =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RW-1:0]   RECIP   = RW'(RECIP_L);

  logic                  busy_q;
  logic                  done_q;
  logic [DIVIDEND_W-1:0] dvd_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [MW-1:0]         prod;

  assign prod = MW'(dvd_q) * MW'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
    end
    if (busy_q) begin
      quo_q <= DIVIDEND_W'(prod >> SHIFT);
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== rtl/windowed_level_alarm_hysteresis_core.sv =====
// Top level: windowed level alarm with hysteresis and buzzer gating.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------------
//  input   | in        | in_valid_i/in_ready_o | kind_i, pm_level_i, sensitivity_raw_i
//  output  | out       | out_valid_o/out_ready_i| accepted_o, activation_level_o,
//          |           |                       | above_count_o, alarm_on_o, buzzer_on_o
//  config  | in        | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// Ticks and rejected measurements are written directly into the output register.
// An accepted measurement has its result registered after the handshake passes
// through one multiply, the reciprocal-multiply threshold divider, a walk over
// the window RAM through its single read port, then one wrap-up. The input is
// held off meanwhile.
// Reset clears control state and the per-entry valid bits; an entry never
// written is masked by its valid bit and never counted, so no clearing pass is needed.
// The output register decouples the sides: a new item is taken while a
// finished result is being handed off, and held off while a result stalls.
`default_nettype none

module windowed_level_alarm_hysteresis_core #(
  parameter int unsigned WINDOW_DEPTH   = wla_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned RAW_FULL_SCALE = wla_pkg::RAW_FULL_SCALE_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // config write port
  input  wire logic                          cfg_we_i,
  input  wire logic [wla_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [wla_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  // input items
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          kind_i,
  input  wire logic [wla_pkg::LEVEL_W-1:0]   pm_level_i,
  input  wire logic [wla_pkg::RAW_W-1:0]     sensitivity_raw_i,
  // result items
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               accepted_o,
  output logic      [wla_pkg::LEVEL_W-1:0]   activation_level_o,
  output logic      [wla_pkg::COUNT_W-1:0]   above_count_o,
  output logic                               alarm_on_o,
  output logic                               buzzer_on_o
);

  localparam int unsigned LW  = wla_pkg::LEVEL_W;
  localparam int unsigned CNW = wla_pkg::COUNT_W;
  localparam int unsigned PW  = wla_pkg::PROD_W;
  localparam int unsigned AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned WCW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [AW-1:0]  LAST_SLOT = AW'(WINDOW_DEPTH - 1);
  localparam logic [WCW-1:0] WALK_END  = WCW'(WINDOW_DEPTH);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [LW-1:0]                 level_min_q, level_max_q, margin_q;
  logic [CNW-1:0]                on_count_q, off_count_q;
  logic [wla_pkg::PERIOD_W-1:0]  period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_min_q <= wla_pkg::LEVEL_MIN_RST;
      level_max_q <= wla_pkg::LEVEL_MAX_RST;
      margin_q    <= wla_pkg::DISABLE_MARGIN_RST;
      on_count_q  <= wla_pkg::ON_COUNT_RST;
      off_count_q <= wla_pkg::OFF_COUNT_RST;
      period_q    <= wla_pkg::UPDATE_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wla_pkg::REG_LEVEL_MIN:      level_min_q <= cfg_wdata_i[LW-1:0];
        wla_pkg::REG_LEVEL_MAX:      level_max_q <= cfg_wdata_i[LW-1:0];
        wla_pkg::REG_DISABLE_MARGIN: margin_q    <= cfg_wdata_i[LW-1:0];
        wla_pkg::REG_ON_COUNT:       on_count_q  <= cfg_wdata_i[CNW-1:0];
        wla_pkg::REG_OFF_COUNT:      off_count_q <= cfg_wdata_i[CNW-1:0];
        wla_pkg::REG_UPDATE_PERIOD:  period_q    <= cfg_wdata_i[wla_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  wla_pkg::wla_state_e           state_q, state_d;
  logic [wla_pkg::PERIOD_W-1:0]  elapsed_q, elapsed_d;
  logic [AW-1:0]                 slot_q, slot_d;
  logic [LW-1:0]                 thr_q, thr_d;
  logic [CNW-1:0]                last_cnt_q, last_cnt_d;
  logic                          alarm_q, alarm_d;
  logic [WINDOW_DEPTH-1:0]       wvalid_q, wvalid_d;
  logic [WCW-1:0]                walk_q, walk_d;
  logic                          rd_pend_q, rd_pend_d;
  logic                          rd_valid_q, rd_valid_d;
  logic [CNW-1:0]                acc_q, acc_d;
  logic [wla_pkg::RAW_W-1:0]     raw_q, raw_d;

  // output register
  logic           out_valid_q, out_valid_d;
  logic           o_acc_q, o_acc_d;
  logic [LW-1:0]  o_thr_q, o_thr_d;
  logic [CNW-1:0] o_cnt_q, o_cnt_d;
  logic           o_alarm_q, o_alarm_d;
  logic           o_buzz_q, o_buzz_d;

  // datapath
  logic           in_fire;
  logic           ram_we;
  logic [AW-1:0]  ram_raddr;
  logic [LW-1:0]  ram_rdata;
  logic [LW-1:0]  span;
  logic [PW-1:0]  product;
  logic           div_start;
  logic           div_done;
  logic [PW-1:0]  quotient;
  logic [PW:0]    thr_sum;
  logic [LW-1:0]  thr_new;
  logic           sample_above;
  logic           alarm_next;

  assign in_ready_o = (state_q == wla_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  // span * knob, registered straight into the divider
  assign span      = (level_max_q >= level_min_q) ? (level_max_q - level_min_q) : '0;
  assign product   = PW'(span) * PW'(raw_q);
  assign div_start = (state_q == wla_pkg::ST_MUL);

  // threshold = min + quotient, saturated to the level width
  assign thr_sum = (PW + 1)'(level_min_q) + (PW + 1)'(quotient);
  assign thr_new = (|thr_sum[PW:LW]) ? {LW{1'b1}} : thr_sum[LW-1:0];

  // never-written entries are masked by their valid bits and never count
  assign sample_above = rd_valid_q && (ram_rdata > thr_q);

  // hysteresis: set at or over on count, clear at or under off count
  always_comb begin
    alarm_next = alarm_q;
    if (!alarm_q && (acc_q >= on_count_q)) begin
      alarm_next = 1'b1;
    end else if (alarm_q && (acc_q <= off_count_q)) begin
      alarm_next = 1'b0;
    end
  end

  function automatic logic buzz(input logic alarm, input logic [15:0] thr,
                                input logic [15:0] margin, input logic [15:0] lmax);
    return alarm && (({1'b0, thr} + {1'b0, margin}) < {1'b0, lmax});
  endfunction

  assign ram_we    = in_fire && (kind_i == wla_pkg::KIND_MEASURE) && (elapsed_q >= period_q);
  assign ram_raddr = walk_q[AW-1:0];

  always_comb begin
    state_d     = state_q;
    elapsed_d   = elapsed_q;
    slot_d      = slot_q;
    thr_d       = thr_q;
    last_cnt_d  = last_cnt_q;
    alarm_d     = alarm_q;
    wvalid_d    = wvalid_q;
    walk_d      = walk_q;
    rd_pend_d   = 1'b0;
    rd_valid_d  = rd_valid_q;
    acc_d       = acc_q;
    raw_d       = raw_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_acc_d     = o_acc_q;
    o_thr_d     = o_thr_q;
    o_cnt_d     = o_cnt_q;
    o_alarm_d   = o_alarm_q;
    o_buzz_d    = o_buzz_q;

    case (state_q)
      wla_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (ram_we) begin
            // measurement taken: window write now, result after the walk
            elapsed_d          = '0;
            wvalid_d[slot_q]   = 1'b1;
            slot_d             = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
            raw_d              = sensitivity_raw_i;
            state_d            = wla_pkg::ST_MUL;
          end else begin
            if (kind_i == wla_pkg::KIND_TICK && elapsed_q != wla_pkg::ELAPSED_MAX) begin
              elapsed_d = elapsed_q + 1'b1;
            end
            out_valid_d = 1'b1;
            o_acc_d     = 1'b0;
            o_thr_d     = thr_q;
            o_cnt_d     = last_cnt_q;
            o_alarm_d   = alarm_q;
            o_buzz_d    = buzz(alarm_q, thr_q, margin_q, level_max_q);
          end
        end
      end
      wla_pkg::ST_MUL: begin
        state_d = wla_pkg::ST_DIV;
      end
      wla_pkg::ST_DIV: begin
        if (div_done) begin
          thr_d   = thr_new;
          walk_d  = '0;
          acc_d   = '0;
          state_d = wla_pkg::ST_WALK;
        end
      end
      wla_pkg::ST_WALK: begin
        // issue one read per cycle, count the entry read the cycle before
        if (walk_q != WALK_END) begin
          rd_pend_d  = 1'b1;
          rd_valid_d = wvalid_q[ram_raddr];
          walk_d     = walk_q + 1'b1;
        end else begin
          state_d = wla_pkg::ST_FIN;
        end
        if (rd_pend_q && sample_above) begin
          acc_d = acc_q + 1'b1;
        end
      end
      wla_pkg::ST_FIN: begin
        last_cnt_d  = acc_q;
        alarm_d     = alarm_next;
        out_valid_d = 1'b1;
        o_acc_d     = 1'b1;
        o_thr_d     = thr_q;
        o_cnt_d     = acc_q;
        o_alarm_d   = alarm_next;
        o_buzz_d    = buzz(alarm_next, thr_q, margin_q, level_max_q);
        state_d     = wla_pkg::ST_IDLE;
      end
      default: begin
        state_d = wla_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wla_pkg::ST_IDLE;
      elapsed_q   <= '0;
      slot_q      <= '0;
      thr_q       <= '0;
      last_cnt_q  <= '0;
      alarm_q     <= 1'b0;
      wvalid_q    <= '0;
      walk_q      <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      elapsed_q   <= elapsed_d;
      slot_q      <= slot_d;
      thr_q       <= thr_d;
      last_cnt_q  <= last_cnt_d;
      alarm_q     <= alarm_d;
      wvalid_q    <= wvalid_d;
      walk_q      <= walk_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_valid_q <= rd_valid_d;
    acc_q      <= acc_d;
    raw_q      <= raw_d;
    o_acc_q    <= o_acc_d;
    o_thr_q    <= o_thr_d;
    o_cnt_q    <= o_cnt_d;
    o_alarm_q  <= o_alarm_d;
    o_buzz_q   <= o_buzz_d;
  end

  // ---------------------------------------------------------------------------
  // Units
  // ---------------------------------------------------------------------------
  wla_ram #(
    .WIDTH (LW),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (pm_level_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  wla_div #(
    .DIVIDEND_W (PW),
    .DIVISOR    (RAW_FULL_SCALE)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign out_valid_o        = out_valid_q;
  assign accepted_o         = o_acc_q;
  assign activation_level_o = o_thr_q;
  assign above_count_o      = o_cnt_q;
  assign alarm_on_o         = o_alarm_q;
  assign buzzer_on_o        = o_buzz_q;

endmodule

`default_nettype wire
